[rtl/core/bsm_pkg.sv]
`default_nettype none
package bsm_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int RAD_W           = 31;
    localparam int GROWTH_W        = 64;
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};
endpackage
`default_nettype wire

[rtl/core/bounding_sphere_merge.sv]
`default_nettype none
// The restoring square root and the three restoring dividers each resolve one result bit
// per pipeline stage.
// Throughput: one request per cycle; the whole pipe freezes only while the result waits.
// Reset (synchronous, active low) clears the stage valid bits; data registers keep garbage.
module bounding_sphere_merge #(
    parameter int COORD_WIDTH = bsm_pkg::COORD_WIDTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [bsm_pkg::FIELD_W-1:0]     i_first_x,
    input  wire  [bsm_pkg::FIELD_W-1:0]     i_first_y,
    input  wire  [bsm_pkg::FIELD_W-1:0]     i_first_z,
    input  wire  [bsm_pkg::RAD_W-1:0]       i_first_radius,
    input  wire  [bsm_pkg::FIELD_W-1:0]     i_second_x,
    input  wire  [bsm_pkg::FIELD_W-1:0]     i_second_y,
    input  wire  [bsm_pkg::FIELD_W-1:0]     i_second_z,
    input  wire  [bsm_pkg::RAD_W-1:0]       i_second_radius,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [bsm_pkg::FIELD_W-1:0]     o_merged_x,
    output logic [bsm_pkg::FIELD_W-1:0]     o_merged_y,
    output logic [bsm_pkg::FIELD_W-1:0]     o_merged_z,
    output logic [bsm_pkg::RAD_W-1:0]       o_merged_radius,
    output logic                            o_overlap,
    output logic [bsm_pkg::GROWTH_W-1:0]    o_growth
);
    import bsm_pkg::*;

    // Effective coordinate width: only the low bits of each field take part.
    localparam int CW  = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    // Width of a centre offset magnitude, of the squared distance and of its root.
    localparam int DW  = CW + 1;
    localparam int SW  = 2 * DW;
    localparam int RW  = DW;
    // The centre shift never exceeds the offset magnitude, so DW quotient bits suffice.
    localparam int QW  = DW;
    localparam int PW  = DW + RAD_W;
    localparam int E2W = 2 * RAD_W;
    // Common width for comparing the squared distance with the squared radii.
    localparam int XW  = (SW > 2*RAD_W+2) ? SW : 2*RAD_W+2;
    // Width of the sum root + r1 + r2.
    localparam int TW  = ((RW > RAD_W) ? RW : RAD_W) + 2;

    // Stage map. Stage 0 captures the request, the square root occupies RW stages,
    // the dividers QW stages, and the last stage is the output register.
    localparam int ST_DELTA = 1;
    localparam int ST_SQR   = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_SQ0   = 4;
    localparam int ST_RAD   = ST_SQ0 + RW;
    localparam int ST_MUL   = ST_RAD + 1;
    localparam int ST_DV0   = ST_MUL + 1;
    localparam int ST_OUT   = ST_DV0 + QW;
    localparam int NS       = ST_OUT + 1;

    typedef struct packed {
        logic [2:0][FIELD_W-1:0] a;
        logic [2:0][FIELD_W-1:0] b;
        logic [RAD_W-1:0]        r1;
        logic [RAD_W-1:0]        r2;
        logic [2:0]              neg;
        logic [2:0][DW-1:0]      mg;
        logic [RAD_W:0]          e;
        logic [RAD_W:0]          rs;
        logic [2:0][SW-1:0]      sq;
        logic [E2W-1:0]          e2;
        logic [2*RAD_W+1:0]      rs2;
        logic [SW-1:0]           s;
        logic [SW-1:0]           s_sh;
        logic [RW+1:0]           srem;
        logic [RW-1:0]           root;
        logic                    enc2;
        logic                    enc1;
        logic                    ovl;
        logic [RAD_W-1:0]        rr;
        logic [RAD_W-1:0]        k;
        logic                    move;
        logic [E2W-1:0]          rr2;
        logic [E2W-1:0]          r1sq;
        logic [GROWTH_W-1:0]     growth;
        logic [2:0][DW-1:0]      drem;
        logic [2:0][QW-1:0]      dlow;
        logic [2:0][QW-1:0]      q;
        logic [2:0][FIELD_W-1:0] c;
    } t_item;

    t_item      r_st  [NS];
    logic [NS-1:0] r_vld;
    logic       en;

    // The pipe advances as one piece whenever the output register is free or drained.
    assign en      = !r_vld[NS-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            t_item n_st;

            if (g == 0) begin : g_cap
                // Capture and sign-extend the coordinates from their low CW bits.
                always_comb begin
                    n_st      = r_st[0];
                    n_st.a[0] = FIELD_W'($signed(i_first_x[CW-1:0]));
                    n_st.a[1] = FIELD_W'($signed(i_first_y[CW-1:0]));
                    n_st.a[2] = FIELD_W'($signed(i_first_z[CW-1:0]));
                    n_st.b[0] = FIELD_W'($signed(i_second_x[CW-1:0]));
                    n_st.b[1] = FIELD_W'($signed(i_second_y[CW-1:0]));
                    n_st.b[2] = FIELD_W'($signed(i_second_z[CW-1:0]));
                    n_st.r1   = i_first_radius;
                    n_st.r2   = i_second_radius;
                end
            end else if (g == ST_DELTA) begin : g_delta
                always_comb begin
                    logic signed [DW-1:0] dl;
                    n_st = r_st[g-1];
                    for (int i = 0; i < 3; i++) begin
                        dl = DW'($signed(r_st[g-1].b[i][CW-1:0]))
                           - DW'($signed(r_st[g-1].a[i][CW-1:0]));
                        n_st.neg[i] = dl[DW-1];
                        n_st.mg[i]  = dl[DW-1] ? DW'(-dl) : DW'(dl);
                    end
                    n_st.e  = {1'b0, r_st[g-1].r2} - {1'b0, r_st[g-1].r1};
                    n_st.rs = {1'b0, r_st[g-1].r1} + {1'b0, r_st[g-1].r2};
                end
            end else if (g == ST_SQR) begin : g_sqr
                always_comb begin
                    logic [RAD_W-1:0] em;
                    n_st = r_st[g-1];
                    for (int i = 0; i < 3; i++) begin
                        n_st.sq[i] = SW'(r_st[g-1].mg[i] * r_st[g-1].mg[i]);
                    end
                    em      = r_st[g-1].e[RAD_W] ? RAD_W'(-r_st[g-1].e)
                                                 : r_st[g-1].e[RAD_W-1:0];
                    n_st.e2  = E2W'(em * em);
                    n_st.rs2 = (2*RAD_W+2)'(r_st[g-1].rs * r_st[g-1].rs);
                end
            end else if (g == ST_SUM) begin : g_sum
                always_comb begin
                    n_st      = r_st[g-1];
                    n_st.s    = r_st[g-1].sq[0] + r_st[g-1].sq[1] + r_st[g-1].sq[2];
                    n_st.s_sh = n_st.s;
                    n_st.srem = '0;
                    n_st.root = '0;
                end
            end else if (g >= ST_SQ0 && g < ST_RAD) begin : g_sqrt
                // One root bit per stage, restoring form.
                always_comb begin
                    logic [RW+3:0] t;
                    logic [RW+3:0] trial;
                    n_st  = r_st[g-1];
                    t     = {r_st[g-1].srem, r_st[g-1].s_sh[SW-1 -: 2]};
                    trial = (RW+4)'({r_st[g-1].root, 2'b01});
                    if (t >= trial) begin
                        n_st.srem = (RW+2)'(t - trial);
                        n_st.root = {r_st[g-1].root[RW-2:0], 1'b1};
                    end else begin
                        n_st.srem = (RW+2)'(t);
                        n_st.root = {r_st[g-1].root[RW-2:0], 1'b0};
                    end
                    n_st.s_sh = {r_st[g-1].s_sh[SW-3:0], 2'b00};
                    if (g == ST_SQ0) begin
                        // Containment and overlap use the exact squares.
                        n_st.enc2 = !r_st[g-1].e[RAD_W]
                                  && (XW'(r_st[g-1].e2) >= XW'(r_st[g-1].s));
                        n_st.enc1 = (r_st[g-1].e[RAD_W] || (r_st[g-1].e == '0))
                                  && (XW'(r_st[g-1].e2) >= XW'(r_st[g-1].s));
                        n_st.ovl  = (XW'(r_st[g-1].s) < XW'(r_st[g-1].rs2));
                    end
                end
            end else if (g == ST_RAD) begin : g_rad
                // R = (d + r1 + r2) / 2 saturated; the shift amount k is R - r1.
                always_comb begin
                    logic [TW-1:0] tot;
                    logic [TW-2:0] half;
                    n_st = r_st[g-1];
                    tot  = TW'(r_st[g-1].root) + TW'(r_st[g-1].r1)
                         + TW'(r_st[g-1].r2);
                    half = tot[TW-1:1];
                    if (half > (TW-1)'(RAD_MAX)) begin
                        n_st.rr = RAD_MAX;
                    end else begin
                        n_st.rr = RAD_W'(half);
                    end
                    n_st.move = (r_st[g-1].root != '0) && (n_st.rr > r_st[g-1].r1);
                    n_st.k    = n_st.move ? (n_st.rr - r_st[g-1].r1) : '0;
                end
            end else if (g == ST_MUL) begin : g_mul
                always_comb begin
                    logic [PW-1:0] p;
                    n_st = r_st[g-1];
                    for (int i = 0; i < 3; i++) begin
                        p            = PW'(r_st[g-1].mg[i] * r_st[g-1].k);
                        n_st.drem[i] = DW'(p >> QW);
                        n_st.dlow[i] = p[QW-1:0];
                        n_st.q[i]    = '0;
                    end
                    n_st.rr2  = E2W'(r_st[g-1].rr * r_st[g-1].rr);
                    n_st.r1sq = E2W'(r_st[g-1].r1 * r_st[g-1].r1);
                end
            end else if (g >= ST_DV0 && g < ST_OUT) begin : g_div
                // One quotient bit per stage for each axis.
                always_comb begin
                    logic [DW:0] t;
                    logic [DW:0] dd;
                    n_st = r_st[g-1];
                    dd   = (DW+1)'(r_st[g-1].root);
                    for (int i = 0; i < 3; i++) begin
                        t = {r_st[g-1].drem[i], r_st[g-1].dlow[i][QW-1]};
                        if (t >= dd) begin
                            n_st.drem[i] = DW'(t - dd);
                            n_st.q[i]    = {r_st[g-1].q[i][QW-2:0], 1'b1};
                        end else begin
                            n_st.drem[i] = DW'(t);
                            n_st.q[i]    = {r_st[g-1].q[i][QW-2:0], 1'b0};
                        end
                        n_st.dlow[i] = {r_st[g-1].dlow[i][QW-2:0], 1'b0};
                    end
                    if (g == ST_DV0) begin
                        n_st.growth = GROWTH_W'(r_st[g-1].rr2) - GROWTH_W'(r_st[g-1].r1sq);
                    end
                end
            end else begin : g_fin
                // Pick the enclosing centre, or shift the first centre toward the second.
                always_comb begin
                    logic [FIELD_W-1:0] q32;
                    n_st = r_st[g-1];
                    for (int i = 0; i < 3; i++) begin
                        q32 = FIELD_W'(r_st[g-1].q[i]);
                        if (r_st[g-1].enc2) begin
                            n_st.c[i] = r_st[g-1].b[i];
                        end else if (r_st[g-1].enc1 || !r_st[g-1].move) begin
                            n_st.c[i] = r_st[g-1].a[i];
                        end else if (r_st[g-1].neg[i]) begin
                            n_st.c[i] = r_st[g-1].a[i] - q32;
                        end else begin
                            n_st.c[i] = r_st[g-1].a[i] + q32;
                        end
                    end
                    if (r_st[g-1].enc2) begin
                        n_st.rr     = r_st[g-1].r2;
                        n_st.growth = GROWTH_W'(r_st[g-1].r2 * r_st[g-1].r2)
                                    - GROWTH_W'(r_st[g-1].r1sq);
                    end else if (r_st[g-1].enc1) begin
                        n_st.rr     = r_st[g-1].r1;
                        n_st.growth = '0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_st[g] <= n_st;
                end
            end
        end
    endgenerate

    assign o_valid         = r_vld[NS-1];
    assign o_merged_x      = r_st[NS-1].c[0];
    assign o_merged_y      = r_st[NS-1].c[1];
    assign o_merged_z      = r_st[NS-1].c[2];
    assign o_merged_radius = r_st[NS-1].rr;
    assign o_overlap       = r_st[NS-1].ovl;
    assign o_growth        = r_st[NS-1].growth;
endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import bsm_pkg::*;

    // The block is instantiated at its default coordinate width.
    localparam int CW = (COORD_WIDTH_DEF < 32) ? COORD_WIDTH_DEF : 32;
    localparam int PIPE_LAT = 6 + 2 * (CW + 1);
    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM = 680;

    // One sphere pair as it is presented to the block.
    typedef struct packed {
        logic [FIELD_W-1:0] ax, ay, az;
        logic [RAD_W-1:0]   ar;
        logic [FIELD_W-1:0] bx, by, bz;
        logic [RAD_W-1:0]   br;
    } t_sphere_pair;

    // One enclosing sphere with its overlap flag and growth.
    typedef struct packed {
        logic [FIELD_W-1:0]  mx, my, mz;
        logic [RAD_W-1:0]    mr;
        logic                ovl;
        logic [GROWTH_W-1:0] grow;
    } t_merged_sphere;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    logic [FIELD_W-1:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic [FIELD_W-1:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic [RAD_W-1:0] i_first_radius = '0, i_second_radius = '0;
    logic [FIELD_W-1:0] o_merged_x, o_merged_y, o_merged_z;
    logic [RAD_W-1:0] o_merged_radius;
    logic o_overlap;
    logic [GROWTH_W-1:0] o_growth;

    always #5 i_clk = ~i_clk;

    bounding_sphere_merge DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_first_x(i_first_x), .i_first_y(i_first_y), .i_first_z(i_first_z),
        .i_first_radius(i_first_radius),
        .i_second_x(i_second_x), .i_second_y(i_second_y), .i_second_z(i_second_z),
        .i_second_radius(i_second_radius),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_merged_x(o_merged_x), .o_merged_y(o_merged_y), .o_merged_z(o_merged_z),
        .o_merged_radius(o_merged_radius), .o_overlap(o_overlap), .o_growth(o_growth)
    );

    t_sphere_pair   pending_pairs[$];
    t_merged_sphere expected_spheres[$];
    int  n_fail = 0;
    int  cycle_count = 0;
    bit  stimulus_done = 1'b0;
    // Random idling is switched off for the last part of the run.
    bit  allow_idle = 1'b1;

    // Low CW bits of a coordinate field, sign-extended.
    function automatic logic signed [63:0] coord_value(logic [FIELD_W-1:0] v);
        logic signed [63:0] w;
        w = $signed({{32{v[31]}}, v});
        if (CW < 32) begin
            w = w <<< (64 - CW);
            w = w >>> (64 - CW);
        end
        return w;
    endfunction

    // floor(sqrt(n)) of a square distance, one result bit per step.
    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= n)
                root = trial;
        end
        return root;
    endfunction

    // Smallest enclosing sphere, computed with wide exact integers.
    function automatic t_merged_sphere merge_spheres(t_sphere_pair p);
        t_merged_sphere res;
        logic signed [63:0] a[3], b[3], dl[3], c[3];
        logic [63:0] mg[3];
        logic [127:0] dist_sq, e_sq, rs_sq, q;
        logic [63:0] r1, r2, rad, root, k, rs;
        logic signed [63:0] e;
        logic [63:0] e_mag;
        a[0] = coord_value(p.ax); a[1] = coord_value(p.ay); a[2] = coord_value(p.az);
        b[0] = coord_value(p.bx); b[1] = coord_value(p.by); b[2] = coord_value(p.bz);
        r1 = 64'(p.ar);
        r2 = 64'(p.br);
        dist_sq = '0;
        for (int i = 0; i < 3; i++) begin
            dl[i] = b[i] - a[i];
            mg[i] = dl[i] < 0 ? 64'(-dl[i]) : 64'(dl[i]);
            dist_sq += 128'(mg[i]) * 128'(mg[i]);
            c[i] = a[i];
        end
        e = $signed(r2) - $signed(r1);
        e_mag = e < 0 ? 64'(-e) : 64'(e);
        e_sq = 128'(e_mag) * 128'(e_mag);
        if (e >= 0 && e_sq >= dist_sq) begin
            // The second sphere encloses the first, equal spheres included.
            for (int i = 0; i < 3; i++) c[i] = b[i];
            rad = r2;
        end else if (e <= 0 && e_sq >= dist_sq) begin
            rad = r1;
        end else begin
            root = floor_root(dist_sq);
            rad = (root + r1 + r2) >> 1;
            if (rad > 64'(RAD_MAX)) rad = 64'(RAD_MAX);
            // With near-coincident centres the root is zero and the first centre stays.
            if (root > 0 && rad > r1) begin
                k = rad - r1;
                for (int i = 0; i < 3; i++) begin
                    q = (128'(mg[i]) * 128'(k)) / 128'(root);
                    c[i] = dl[i] < 0 ? a[i] - $signed(q[63:0]) : a[i] + $signed(q[63:0]);
                end
            end
        end
        rs = r1 + r2;
        rs_sq = 128'(rs) * 128'(rs);
        res.mx = c[0][31:0];
        res.my = c[1][31:0];
        res.mz = c[2][31:0];
        res.mr = rad[RAD_W-1:0];
        res.ovl = dist_sq < rs_sq;
        res.grow = rad * rad - r1 * r1;
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            3: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] rand_radius();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RAD_MAX;
            2: return RAD_W'($urandom_range(0, 32'h0010_0000));
            3: return RAD_W'($urandom_range(0, 32'h0400_0000));
            default: return RAD_W'($urandom);
        endcase
    endfunction

    // Random pair; often the second sphere is placed near the first so that
    // containment, overlap and coincident centres all show up.
    function automatic t_sphere_pair rand_pair();
        t_sphere_pair p;
        p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
        p.ar = rand_radius();
        p.br = rand_radius();
        case ($urandom_range(0, 3))
            0: begin
                p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
            end
            1: begin
                p.bx = p.ax + $urandom_range(0, 64) - 32;
                p.by = p.ay + $urandom_range(0, 64) - 32;
                p.bz = p.az + $urandom_range(0, 64) - 32;
            end
            default: begin
                p.bx = p.ax + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                p.by = p.ay + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                p.bz = p.az + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            end
        endcase
        return p;
    endfunction

    function automatic t_sphere_pair make_pair(logic [31:0] ax, ay, az, ar,
                                               logic [31:0] bx, by, bz, br);
        t_sphere_pair p;
        p.ax = ax; p.ay = ay; p.az = az; p.ar = ar[RAD_W-1:0];
        p.bx = bx; p.by = by; p.bz = bz; p.br = br[RAD_W-1:0];
        return p;
    endfunction

    // Driver: presents requests from the pending queue, with random gaps.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    t_sphere_pair p;
                    p = pending_pairs.pop_front();
                    expected_spheres.push_back(merge_spheres(p));
                    i_first_x <= p.ax; i_first_y <= p.ay; i_first_z <= p.az;
                    i_first_radius <= p.ar;
                    i_second_x <= p.bx; i_second_y <= p.by; i_second_z <= p.bz;
                    i_second_radius <= p.br;
                    i_valid <= 1'b1;
                    if (allow_idle && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure in random bursts.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: each accepted result is checked against the oldest expectation.
    // The expectation is queued when the request is loaded, which always
    // precedes its result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_spheres.size() == 0) begin
                $error("result with no request outstanding");
                n_fail <= n_fail + 1;
            end else begin
                t_merged_sphere x;
                int bad;
                x = expected_spheres.pop_front();
                bad = 0;
                if (o_merged_x !== x.mx) begin
                    $error("merged_x expected %h actual %h", x.mx, o_merged_x); bad++;
                end
                if (o_merged_y !== x.my) begin
                    $error("merged_y expected %h actual %h", x.my, o_merged_y); bad++;
                end
                if (o_merged_z !== x.mz) begin
                    $error("merged_z expected %h actual %h", x.mz, o_merged_z); bad++;
                end
                if (o_merged_radius !== x.mr) begin
                    $error("merged_radius expected %h actual %h", x.mr, o_merged_radius);
                    bad++;
                end
                if (o_overlap !== x.ovl) begin
                    $error("overlap expected %b actual %b", x.ovl, o_overlap); bad++;
                end
                if (o_growth !== x.grow) begin
                    $error("growth expected %h actual %h", x.grow, o_growth); bad++;
                end
                if (bad != 0) n_fail <= n_fail + 1;
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // Directed cases: extremes, equal spheres, containment either way,
        // coincident centres, saturated radius, strict overlap boundary.
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 2, 3, 32'h10000, 1, 2, 3, 32'h10000));
        pending_pairs.push_back(make_pair(0, 0, 0, 32'h50000, 32'h10000, 0, 0, 32'h10000));
        pending_pairs.push_back(make_pair(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h50000));
        pending_pairs.push_back(make_pair(5, 5, 5, 32'h10000, 6, 5, 5, 32'h10000));
        pending_pairs.push_back(make_pair(0, 0, 0, 32'h10000, 32'h30000, 0, 0, 32'h20000));
        pending_pairs.push_back(make_pair(0, 0, 0, 32'h10000, 32'h40000, 0, 0, 32'h10000));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
                                          32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        pending_pairs.push_back(make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 0, 32'h8000_0000, 0));
        pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                          32'h1, 32'h1, 32'h1, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                          32'h2AAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                                          32'hAAAA_AAAA, 32'h5555_5555));
        pending_pairs.push_back(make_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h100, 0, 0, 0));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            pending_pairs.push_back(rand_pair());
            // The last stretch runs with no idling at all.
            if (i == N_RANDOM - 100) begin
                wait (pending_pairs.size() == 0);
                allow_idle = 1'b0;
            end
        end
        wait (pending_pairs.size() == 0 && !(i_valid && !o_ready));
        @(posedge i_clk);
        wait (expected_spheres.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
